// File: hw/rtl/cbq_pkg.sv
// Shared constants, codes and types of the complex biquad cascade filter.
package cbq_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned MAX_SECTIONS_DEF = 4;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned COEF_WIDTH_DEF   = 20;

  // Delay words are Q9.31 at the default sample and coefficient widths.
  localparam int unsigned DELAY_WIDTH = 40;

  // Coefficients held by one section and the width of their slot code.
  localparam int unsigned COEFS_PER_SECTION = 5;
  localparam int unsigned SLOT_WIDTH        = 3;

  // Item command carried on the input channel.
  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_COEF   = 1'b1
  } cbq_cmd_e;

  // Coefficient slot within one section.
  typedef enum logic [SLOT_WIDTH-1:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } cbq_slot_e;

  // Sequence of one section cell while it works on a sample.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_X,
    PH_ACC,
    PH_MUL_Y,
    PH_UPDATE
  } cbq_phase_e;

  // Control that travels with a sample from cell to cell.
  typedef struct packed {
    logic valid;
    logic clip;
  } cbq_beat_t;

  // Commands from the top level to each cell; only the addressed cell sees coef_we.
  typedef struct packed {
    logic      clear;
    logic      coef_we;
    cbq_slot_e coef_slot;
  } cbq_cell_cmd_t;

endpackage

// File: hw/rtl/cbq_if.sv
// Channel interfaces of the complex biquad cascade filter.
interface cbq_in_if import cbq_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int unsigned SEC_WIDTH    = 2
);
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic                           first_in_channel;
  logic signed [SAMPLE_WIDTH-1:0] sample_real;
  logic signed [SAMPLE_WIDTH-1:0] sample_imag;
  logic [SEC_WIDTH-1:0]           coef_section;
  logic [SLOT_WIDTH-1:0]          coef_slot;
  logic signed [COEF_WIDTH-1:0]   coef_value;

  modport source (
    output valid, cmd, first_in_channel, sample_real, sample_imag,
           coef_section, coef_slot, coef_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_in_channel, sample_real, sample_imag,
           coef_section, coef_slot, coef_value,
    output ready
  );
endinterface

interface cbq_out_if import cbq_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] result_real;
  logic signed [SAMPLE_WIDTH-1:0] result_imag;
  logic                           clipped;

  modport source (output valid, result_real, result_imag, clipped, input ready);
  modport sink (input valid, result_real, result_imag, clipped, output ready);
endinterface

interface cbq_cfg_if #(
  parameter int unsigned CNT_WIDTH = 3
);
  logic                 valid;
  logic                 ready;
  logic [CNT_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/cbq_cell.sv
// One biquad section cell: coefficients, complex delay words and a four-step sequencer.
module cbq_cell import cbq_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           active_i,
  input  cbq_cell_cmd_t                  cmd_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_value_i,
  input  cbq_beat_t                      beat_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  output cbq_beat_t                      beat_o,
  output logic signed [SAMPLE_WIDTH-1:0] re_o,
  output logic signed [SAMPLE_WIDTH-1:0] im_o
);

  localparam int unsigned PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int unsigned ACC_W  = ((PROD_W > DELAY_WIDTH) ? PROD_W : DELAY_WIDTH) + 2;
  localparam int unsigned SH     = COEF_WIDTH - 4;
  localparam int unsigned YF_W   = ACC_W - SH;

  localparam logic signed [ACC_W-1:0]        RND   = ACC_W'(1) << (SH - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [DELAY_WIDTH-1:0]  W_MAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
  localparam logic signed [DELAY_WIDTH-1:0]  W_MIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};

  cbq_phase_e phase_q, phase_d;
  logic       ld_x, ld_p, ld_y, ld_q, ld_w, bypass;

  logic signed [COEF_WIDTH-1:0]   coef_q [COEFS_PER_SECTION];
  // Index 0 holds the real part, index 1 the imaginary part.
  logic signed [SAMPLE_WIDTH-1:0] x_q  [2];
  logic signed [PROD_W-1:0]       p0_q [2], p1_q [2], p2_q [2];
  logic signed [PROD_W-1:0]       p0_d [2], p1_d [2], p2_d [2];
  logic signed [SAMPLE_WIDTH-1:0] y_q  [2], y_d [2];
  logic signed [PROD_W-1:0]       q3_q [2], q4_q [2], q3_d [2], q4_d [2];
  logic signed [DELAY_WIDTH-1:0]  w1_q [2], w2_q [2], w1_d [2], w2_d [2];
  logic signed [ACC_W-1:0]        acc  [2], w1_sum [2], w2_sum [2];
  logic        [YF_W-1:0]         yf   [2];
  logic                           y_hit [2];
  logic                           clip_q;
  logic                           out_valid_q, out_clip_q;
  logic signed [SAMPLE_WIDTH-1:0] out_re_q, out_im_q;

  // Sequencer: multiply by x, accumulate and round, multiply by y, update delays.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (beat_i.valid && active_i) phase_d = PH_MUL_X;
      end
      PH_MUL_X:  phase_d = PH_ACC;
      PH_ACC:    phase_d = PH_MUL_Y;
      PH_MUL_Y:  phase_d = PH_UPDATE;
      PH_UPDATE: phase_d = PH_IDLE;
      default:   phase_d = PH_IDLE;
    endcase
  end

  // Load strobes for each step.
  always_comb begin
    ld_x   = 1'b0;
    ld_p   = 1'b0;
    ld_y   = 1'b0;
    ld_q   = 1'b0;
    ld_w   = 1'b0;
    bypass = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        ld_x   = beat_i.valid && active_i;
        bypass = beat_i.valid && !active_i;
      end
      PH_MUL_X:  ld_p = 1'b1;
      PH_ACC:    ld_y = 1'b1;
      PH_MUL_Y:  ld_q = 1'b1;
      PH_UPDATE: ld_w = 1'b1;
      default: begin
        ld_x = 1'b0;
      end
    endcase
  end

  // Arithmetic of both parts, which share the real coefficients.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      p0_d[k] = coef_q[SLOT_B0] * x_q[k];
      p1_d[k] = coef_q[SLOT_B1] * x_q[k];
      p2_d[k] = coef_q[SLOT_B2] * x_q[k];

      // Round to nearest by adding half an LSB and flooring, then saturate.
      acc[k]   = ACC_W'(p0_q[k]) + ACC_W'(w1_q[k]) + RND;
      yf[k]    = acc[k][ACC_W-1:SH];
      y_hit[k] = !((&yf[k][YF_W-1:SAMPLE_WIDTH-1]) || !(|yf[k][YF_W-1:SAMPLE_WIDTH-1]));
      if (y_hit[k]) begin
        y_d[k] = yf[k][YF_W-1] ? Y_MIN : Y_MAX;
      end else begin
        y_d[k] = yf[k][SAMPLE_WIDTH-1:0];
      end

      q3_d[k] = coef_q[SLOT_A1] * y_q[k];
      q4_d[k] = coef_q[SLOT_A2] * y_q[k];

      // New delay words are formed exactly and saturated to the delay width.
      w1_sum[k] = ACC_W'(p1_q[k]) - ACC_W'(q3_q[k]) + ACC_W'(w2_q[k]);
      w2_sum[k] = ACC_W'(p2_q[k]) - ACC_W'(q4_q[k]);
      if ((&w1_sum[k][ACC_W-1:DELAY_WIDTH-1]) || !(|w1_sum[k][ACC_W-1:DELAY_WIDTH-1])) begin
        w1_d[k] = w1_sum[k][DELAY_WIDTH-1:0];
      end else begin
        w1_d[k] = w1_sum[k][ACC_W-1] ? W_MIN : W_MAX;
      end
      if ((&w2_sum[k][ACC_W-1:DELAY_WIDTH-1]) || !(|w2_sum[k][ACC_W-1:DELAY_WIDTH-1])) begin
        w2_d[k] = w2_sum[k][DELAY_WIDTH-1:0];
      end else begin
        w2_d[k] = w2_sum[k][ACC_W-1] ? W_MIN : W_MAX;
      end
    end
  end

  // Control, coefficients and delay words, all cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < COEFS_PER_SECTION; i++) coef_q[i] <= '0;
      for (int k = 0; k < 2; k++) begin
        w1_q[k] <= '0;
        w2_q[k] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= ld_w || bypass;
      if (cmd_i.coef_we) coef_q[cmd_i.coef_slot] <= coef_value_i;
      for (int k = 0; k < 2; k++) begin
        if (cmd_i.clear) begin
          w1_q[k] <= '0;
          w2_q[k] <= '0;
        end else if (ld_w) begin
          w1_q[k] <= w1_d[k];
          w2_q[k] <= w2_d[k];
        end
      end
    end
  end

  // Datapath pipeline registers.
  always_ff @(posedge clk_i) begin
    if (ld_x) begin
      x_q[0] <= re_i;
      x_q[1] <= im_i;
      clip_q <= beat_i.clip;
    end
    if (ld_y) clip_q <= clip_q || y_hit[0] || y_hit[1];
    for (int k = 0; k < 2; k++) begin
      if (ld_p) begin
        p0_q[k] <= p0_d[k];
        p1_q[k] <= p1_d[k];
        p2_q[k] <= p2_d[k];
      end
      if (ld_y) y_q[k] <= y_d[k];
      if (ld_q) begin
        q3_q[k] <= q3_d[k];
        q4_q[k] <= q4_d[k];
      end
    end
    // Hand the section output, or the untouched input of a switched-off cell, on.
    if (ld_w) begin
      out_re_q   <= y_q[0];
      out_im_q   <= y_q[1];
      out_clip_q <= clip_q;
    end else if (bypass) begin
      out_re_q   <= re_i;
      out_im_q   <= im_i;
      out_clip_q <= beat_i.clip;
    end
  end

  assign beat_o.valid = out_valid_q;
  assign beat_o.clip  = out_clip_q;
  assign re_o         = out_re_q;
  assign im_o         = out_im_q;

endmodule

// File: hw/rtl/complex_biquad_cascade_filter.sv
// Top level of the complex biquad cascade filter: a chain of section cells.
//
// Items arrive on in_i. A coefficient beat (cmd set) writes one coefficient of
// one section in the cycle it is accepted and gives no result; a write to a
// slot above a2 or to a section beyond the chain is dropped. A sample beat
// walks down the chain of MAX_SECTIONS cells; each active cell works through
// capture, multiply by x, round the output, multiply by y and update the
// delay words, while a switched-off cell passes it on in the next cycle.
// A sample marked first in channel clears every delay word as it is accepted.
// One sample is in the chain at a time, so the next beat is accepted in the
// cycle after the result has entered the output register.
// The result waits in the output register while out_o is stalled; a following
// sample is still accepted and filtered, then held until the register frees.
// cfg_i is always ready and sets the number of active sections; the user must
// write it only while the block is idle, as the block does not enforce this.
// Reset clears coefficients and delay words and selects one active section.
module complex_biquad_cascade_filter import cbq_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cbq_in_if.sink    in_i,
  cbq_out_if.source out_o,
  cbq_cfg_if.sink   cfg_i
);

  localparam int unsigned SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

  logic [CNT_W-1:0] active_q, n_eff;
  logic             busy_q, pend_q;
  logic             in_beat, sample_beat, coef_ok, move;
  cbq_cell_cmd_t    cell_cmd [MAX_SECTIONS];

  cbq_beat_t                      beat [MAX_SECTIONS+1];
  logic signed [SAMPLE_WIDTH-1:0] re   [MAX_SECTIONS+1];
  logic signed [SAMPLE_WIDTH-1:0] im   [MAX_SECTIONS+1];

  logic signed [SAMPLE_WIDTH-1:0] res_re_q, res_im_q, out_re_q, out_im_q;
  logic                           res_clip_q, out_clip_q, out_valid_q;

  // Input handshake and decode.
  assign in_i.ready  = !busy_q;
  assign in_beat     = in_i.valid && !busy_q;
  assign sample_beat = in_beat && (in_i.cmd == CMD_SAMPLE);
  assign coef_ok     = in_beat && (in_i.cmd == CMD_COEF)
                    && (in_i.coef_slot < SLOT_WIDTH'(COEFS_PER_SECTION))
                    && ({1'b0, in_i.coef_section} < (SEC_W+1)'(MAX_SECTIONS));

  // Active section count, with zero read as one and overflow as the chain length.
  always_comb begin
    if (active_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (active_q > CNT_W'(MAX_SECTIONS)) begin
      n_eff = CNT_W'(MAX_SECTIONS);
    end else begin
      n_eff = active_q;
    end
  end

  // The sample enters the first cell straight from the channel.
  assign beat[0].valid = sample_beat;
  assign beat[0].clip  = 1'b0;
  assign re[0]         = in_i.sample_real;
  assign im[0]         = in_i.sample_imag;

  // Chain of section cells.
  for (genvar s = 0; s < MAX_SECTIONS; s++) begin : g_cell
    assign cell_cmd[s].clear     = sample_beat && in_i.first_in_channel;
    assign cell_cmd[s].coef_we   = coef_ok && (in_i.coef_section == SEC_W'(s));
    assign cell_cmd[s].coef_slot = cbq_slot_e'(in_i.coef_slot);

    cbq_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .active_i     (CNT_W'(s) < n_eff),
      .cmd_i        (cell_cmd[s]),
      .coef_value_i (in_i.coef_value),
      .beat_i       (beat[s]),
      .re_i         (re[s]),
      .im_i         (im[s]),
      .beat_o       (beat[s+1]),
      .re_o         (re[s+1]),
      .im_o         (im[s+1])
    );
  end

  // The finished result moves to the output register once that is free.
  assign move = pend_q && (!out_valid_q || out_o.ready);

  // Control flags and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= CNT_W'(1);
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) active_q <= cfg_i.data;
      if (sample_beat) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (beat[MAX_SECTIONS].valid) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result holding and output registers.
  always_ff @(posedge clk_i) begin
    if (beat[MAX_SECTIONS].valid) begin
      res_re_q   <= re[MAX_SECTIONS];
      res_im_q   <= im[MAX_SECTIONS];
      res_clip_q <= beat[MAX_SECTIONS].clip;
    end
    if (move) begin
      out_re_q   <= res_re_q;
      out_im_q   <= res_im_q;
      out_clip_q <= res_clip_q;
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_real = out_re_q;
  assign out_o.result_imag = out_im_q;
  assign out_o.clipped     = out_clip_q;

endmodule

// File: hw/rtl/cbq_checker.sv
// Port-level checks of the complex biquad cascade filter, bound to the top level.
module cbq_checker import cbq_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_cmd_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_real_i,
  input logic [SAMPLE_WIDTH-1:0] out_imag_i,
  input logic                    out_clipped_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // A stalled result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable({out_real_i, out_imag_i, out_clipped_i}))
    else $error("result changed or dropped while stalled");

  // Once a sample beat is taken, the block is busy with it in the next cycle.
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_cmd_i == CMD_SAMPLE) |=> !in_ready_i)
    else $error("input ready straight after a sample beat");

  // A coefficient beat taken with nothing in flight brings no result.
  a_coef_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_cmd_i == CMD_COEF) && !out_valid_i |=> !out_valid_i)
    else $error("result appeared after a coefficient write");

  // A result never appears in the cycle straight after an input beat.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_beat))
    else $error("result appeared one cycle after an input beat");

endmodule

bind complex_biquad_cascade_filter cbq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cbq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_cmd_i      (in_i.cmd),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_real_i    (out_o.result_real),
  .out_imag_i    (out_o.result_imag),
  .out_clipped_i (out_o.clipped)
);

// File: verif/complex_biquad_cascade_filter_test.sv
// Self-checking testbench of the complex biquad cascade filter: predictor, drivers and checks.

// One beat of the input channel, at the block's field widths.
typedef struct packed {
  cbq_pkg::cbq_cmd_e                             cmd;
  logic                                          first;
  logic signed [cbq_pkg::SAMPLE_WIDTH_DEF-1:0]   re;
  logic signed [cbq_pkg::SAMPLE_WIDTH_DEF-1:0]   im;
  logic [$clog2(cbq_pkg::MAX_SECTIONS_DEF)-1:0]  section;
  logic [cbq_pkg::SLOT_WIDTH-1:0]                slot;
  logic signed [cbq_pkg::COEF_WIDTH_DEF-1:0]     value;
} filter_item_t;

// One filtered output sample.
typedef struct packed {
  logic signed [cbq_pkg::SAMPLE_WIDTH_DEF-1:0] re;
  logic signed [cbq_pkg::SAMPLE_WIDTH_DEF-1:0] im;
  logic                                        clip;
} filtered_t;

// Tracks the filter state, predicts each output and checks what comes out.
class cascade_tracker;
  localparam int unsigned NSEC = cbq_pkg::MAX_SECTIONS_DEF;
  localparam int unsigned NCOEF = cbq_pkg::COEFS_PER_SECTION;
  localparam int unsigned SW = cbq_pkg::SAMPLE_WIDTH_DEF;
  localparam int unsigned DW = cbq_pkg::DELAY_WIDTH;
  localparam int unsigned FRAC = cbq_pkg::COEF_WIDTH_DEF - 4;

  logic signed [cbq_pkg::COEF_WIDTH_DEF-1:0] coef [NSEC*NCOEF];
  logic signed [DW-1:0] w1_re [NSEC];
  logic signed [DW-1:0] w1_im [NSEC];
  logic signed [DW-1:0] w2_re [NSEC];
  logic signed [DW-1:0] w2_im [NSEC];
  int unsigned sections_in_use;
  filtered_t awaited_outputs [$];
  int unsigned errors;
  int unsigned outputs_checked;
  int unsigned clipped_outputs;

  function new();
    foreach (coef[i]) coef[i] = '0;
    clear_delays();
    sections_in_use = 1;
    errors = 0;
    outputs_checked = 0;
    clipped_outputs = 0;
  endfunction

  function void clear_delays();
    for (int s = 0; s < NSEC; s++) begin
      w1_re[s] = '0;
      w1_im[s] = '0;
      w2_re[s] = '0;
      w2_im[s] = '0;
    end
  endfunction

  // A count of zero acts as one, anything past the chain as the whole chain.
  function void set_sections(logic [2:0] v);
    sections_in_use = (v == 0) ? 1 : ((v > NSEC) ? NSEC : int'(v));
  endfunction

  function longint clamp_to(longint v, int unsigned w, inout bit hit);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One section on one part: round the output to Q1.15, then update the delays.
  function longint section_part(int unsigned s, longint x, inout logic signed [DW-1:0] d1,
                                inout logic signed [DW-1:0] d2, inout bit clip);
    longint acc;
    longint y;
    bit dropped;
    int unsigned b;
    b = s * NCOEF;
    dropped = 1'b0;
    acc = longint'(coef[b + cbq_pkg::SLOT_B0]) * x + longint'(d1);
    y = clamp_to((acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC, SW, clip);
    d1 = DW'(clamp_to(longint'(coef[b + cbq_pkg::SLOT_B1]) * x
                      - longint'(coef[b + cbq_pkg::SLOT_A1]) * y + longint'(d2), DW, dropped));
    d2 = DW'(clamp_to(longint'(coef[b + cbq_pkg::SLOT_B2]) * x
                      - longint'(coef[b + cbq_pkg::SLOT_A2]) * y, DW, dropped));
    return y;
  endfunction

  // Called for every accepted input beat.
  function void accept_item(filter_item_t it);
    longint xr;
    longint xi;
    bit clip;
    filtered_t r;
    if (it.cmd == cbq_pkg::CMD_COEF) begin
      if (it.section < NSEC && it.slot < NCOEF) coef[it.section * NCOEF + it.slot] = it.value;
      return;
    end
    if (it.first) clear_delays();
    xr = longint'(it.re);
    xi = longint'(it.im);
    clip = 1'b0;
    for (int unsigned s = 0; s < sections_in_use; s++) begin
      xr = section_part(s, xr, w1_re[s], w2_re[s], clip);
      xi = section_part(s, xi, w1_im[s], w2_im[s], clip);
    end
    r.re = SW'(xr);
    r.im = SW'(xi);
    r.clip = clip;
    awaited_outputs.insert(awaited_outputs.size(), r);
  endfunction

  // Called for every accepted output beat.
  function void check_result(filtered_t got);
    filtered_t want;
    outputs_checked++;
    if (got.clip === 1'b1) clipped_outputs++;
    if (awaited_outputs.size() == 0) begin
      $error("output beat with nothing outstanding: re %0d im %0d clipped %0b",
             got.re, got.im, got.clip);
      errors++;
      return;
    end
    want = awaited_outputs.pop_front();
    if (got.re !== want.re) begin
      $error("result_real: expected %0d, actual %0d", want.re, got.re);
      errors++;
    end
    if (got.im !== want.im) begin
      $error("result_imag: expected %0d, actual %0d", want.im, got.im);
      errors++;
    end
    if (got.clip !== want.clip) begin
      $error("clipped: expected %0b, actual %0b", want.clip, got.clip);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return awaited_outputs.size();
  endfunction
endclass

module complex_biquad_cascade_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cbq_pkg::*;

  localparam int unsigned NSEC = MAX_SECTIONS_DEF;
  // Longest sample latency with every section on, plus margin.
  localparam int unsigned SETTLE_CYCLES = 5 * NSEC + 8;
  localparam int unsigned TIMEOUT_NS = 5_000_000;
  localparam logic signed [SAMPLE_WIDTH_DEF-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_WIDTH_DEF-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_MAX = 20'sh7ffff;
  localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_MIN = 20'sh80000;
  localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_ONE = 20'sh10000;
  localparam logic signed [COEF_WIDTH_DEF-1:0] COEF_HALF = 20'sh08000;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit calm;
  int unsigned beats_sent;
  int unsigned coef_beats;
  cascade_tracker board;

  cbq_in_if in_bus ();
  cbq_out_if out_bus ();
  cbq_cfg_if cfg_bus ();

  complex_biquad_cascade_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random idle length: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 72) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly moderate coefficients so the cascade stays in range, some extremes.
  function automatic logic signed [COEF_WIDTH_DEF-1:0] pick_coef();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return COEF_WIDTH_DEF'(int'($urandom_range(0, 65536)) - 32768);
    if (r < 8) return COEF_WIDTH_DEF'(int'($urandom_range(0, 131072)) - 65536);
    if (r < 9) return COEF_WIDTH_DEF'($urandom);
    return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return SMP_MAX;
    if (r == 1) return SMP_MIN;
    if (r < 4) return SAMPLE_WIDTH_DEF'(int'($urandom_range(0, 512)) - 256);
    return SAMPLE_WIDTH_DEF'($urandom);
  endfunction

  // Output side: random back-pressure, released while the run is calm.
  initial begin
    int unsigned hold;
    int unsigned r;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r >= 96) hold = $urandom_range(10, 40);
        else if (r >= 75) hold = $urandom_range(1, 3);
      end
      out_bus.ready <= (hold == 0);
      if (hold != 0) hold--;
    end
  end

  // Every accepted output beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      board.check_result('{re: out_bus.result_real, im: out_bus.result_imag,
                           clip: out_bus.clipped});
  end

  // Drive one beat after a random gap and wait for it to be taken.
  task automatic push_item(input filter_item_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid            <= 1'b1;
    in_bus.cmd              <= it.cmd;
    in_bus.first_in_channel <= it.first;
    in_bus.sample_real      <= it.re;
    in_bus.sample_imag      <= it.im;
    in_bus.coef_section     <= it.section;
    in_bus.coef_slot        <= it.slot;
    in_bus.coef_value       <= it.value;
    do @(posedge clk_i); while (!in_bus.ready);
    board.accept_item(it);
    beats_sent++;
    if (it.cmd == CMD_COEF) coef_beats++;
  endtask

  // Sample beat; the coefficient fields carry noise.
  task automatic send_sample(input logic first, input logic signed [SAMPLE_WIDTH_DEF-1:0] re,
                             input logic signed [SAMPLE_WIDTH_DEF-1:0] im);
    push_item('{cmd: CMD_SAMPLE, first: first, re: re, im: im, section: 2'($urandom),
                slot: 3'($urandom), value: 20'($urandom)});
  endtask

  // Coefficient beat; the sample fields carry noise.
  task automatic write_coef(input int unsigned sec, input int unsigned slot,
                            input logic signed [COEF_WIDTH_DEF-1:0] value);
    push_item('{cmd: CMD_COEF, first: 1'($urandom), re: 16'($urandom), im: 16'($urandom),
                section: 2'(sec), slot: 3'(slot), value: value});
  endtask

  // Stop sending and wait until every predicted output has been seen.
  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_sections(input logic [2:0] count);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= count;
    do @(posedge clk_i); while (!cfg_bus.ready);
    board.set_sections(count);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Section counts visited, out-of-range values and both extremes among them.
  logic [2:0] section_plan [9] = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd4};

  initial begin
    int unsigned count;
    int unsigned left_in_channel;
    logic first;
    board = new();
    calm = 1'b0;
    beats_sent = 0;
    coef_beats = 0;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_SAMPLE;
    in_bus.first_in_channel = 1'b0;
    in_bus.sample_real = '0;
    in_bus.sample_imag = '0;
    in_bus.coef_section = '0;
    in_bus.coef_slot = SLOT_B0;
    in_bus.coef_value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset setting of one section.
    // Zero coefficients after reset give silence.
    send_sample(1'b1, SMP_MAX, SMP_MIN);
    // Unity gain passes both extremes through.
    write_coef(0, SLOT_B0, COEF_ONE);
    send_sample(1'b0, SMP_MAX, SMP_MIN);
    // Largest and smallest gains saturate the output and raise the flag.
    write_coef(0, SLOT_B0, COEF_MAX);
    send_sample(1'b0, SMP_MAX, SMP_MIN);
    write_coef(0, SLOT_B0, COEF_MIN);
    send_sample(1'b0, SMP_MIN, 16'sd0);
    // Half gain shows the rounding of odd values on either sign.
    write_coef(0, SLOT_B0, COEF_HALF);
    send_sample(1'b0, 16'sd1, -16'sd1);
    send_sample(1'b0, 16'sd3, -16'sd3);
    // Feedforward terms at half gain and feedback terms at their extremes.
    write_coef(0, SLOT_B1, COEF_HALF);
    write_coef(0, SLOT_B2, -COEF_HALF);
    write_coef(0, SLOT_A1, COEF_MIN);
    write_coef(0, SLOT_A2, COEF_MAX);
    send_sample(1'b0, SMP_MAX, SMP_MIN);
    send_sample(1'b0, 16'sd0, 16'sd0);
    send_sample(1'b0, 16'sd0, 16'sd0);
    // Writes to a slot past a2 are dropped.
    write_coef(0, COEFS_PER_SECTION, COEF_MAX);
    write_coef(0, 7, COEF_MIN);
    // A switched-off section can be loaded without touching the output.
    write_coef(NSEC - 1, SLOT_B0, COEF_MAX);
    send_sample(1'b0, 16'sd1000, -16'sd1000);
    // Starting a channel clears the held delay words.
    send_sample(1'b1, 16'sd1000, -16'sd1000);
    send_sample(1'b0, SMP_MIN, SMP_MAX);

    // Random part: one phase per section setting.
    foreach (section_plan[p]) begin
      calm = (p % 3 == 1);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_sections(section_plan[p]);
      for (int s = 0; s < NSEC; s++)
        for (int k = 0; k < COEFS_PER_SECTION; k++) write_coef(s, k, pick_coef());
      repeat ($urandom_range(1, 3))
        write_coef($urandom_range(0, NSEC - 1), $urandom_range(COEFS_PER_SECTION, 7),
                   20'($urandom));
      count = $urandom_range(60, 80);
      // Now and then the first channel resumes from the delay words still held.
      left_in_channel = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      for (int i = 0; i < count; i++) begin
        // Once per phase the sender waits for the filter to empty.
        if (i == count / 2) wait_drained();
        if ($urandom_range(0, 24) == 0)
          write_coef($urandom_range(0, NSEC - 1), $urandom_range(0, 7), pick_coef());
        first = (left_in_channel == 0);
        if (first) left_in_channel = $urandom_range(1, 20);
        left_in_channel--;
        send_sample(first, pick_sample(), pick_sample());
      end
    end

    // Let everything come out, then allow time for anything spurious.
    calm = 1'b0;
    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d beats (%0d coefficient writes) over %0d section settings.",
             beats_sent, coef_beats, $size(section_plan) + 1);
    $display("Checked %0d filtered samples, %0d of them clipped.",
             board.outputs_checked, board.clipped_outputs);
    if (board.errors == 0) begin
      $display("complex_biquad_cascade_filter verification clean");
    end else begin
      $display("complex_biquad_cascade_filter verification failed");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("complex_biquad_cascade_filter verification failed");
    $finish;
  end
endmodule
